[hdl/ogru_pkg.sv]
// Shared types and constants for the occupancy grid ray update block.
// Used by ogru_ctrl, ogru_dp and occupancy_grid_ray_update; no dependencies.
package ogru_pkg;

   localparam int COORD_W = 8;   // cell column / row
   localparam int ODDS_W  = 7;   // hit / miss odds registers
   localparam int CELL_W  = 8;   // signed log-odds cell
   localparam int CNT_W   = 9;   // cleared-cell count
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_HIT_ODDS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_ODDS = 1'b1;

   localparam logic [ODDS_W-1:0] HIT_ODDS_RST  = 7'd3;
   localparam logic [ODDS_W-1:0] MISS_ODDS_RST = 7'd1;

   localparam logic signed [CELL_W-1:0] CELL_MAX = 8'sd127;
   localparam logic signed [CELL_W-1:0] CELL_MIN = -8'sd127;

   // func field codes
   localparam logic FUNC_RAY  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_LOOK  = 6'b001000,
      ST_WALK  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;   // write zero at sweep address, advance sweep
      logic load;    // capture accepted item
      logic setup;   // line setup, read target cell
      logic look;    // target data back: hit update or read result
      logic walk;    // issue read of next free cell
      logic emit;    // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic walk_done;
      logic rsp_free;
   } status_type;

endpackage

[hdl/ogru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ogru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[hdl/ogru_ctrl.sv]
// Sequencer for the grid: clearing sweep, item intake, hit update,
// line walk and result hand-off. Depends on ogru_pkg.
module ogru_ctrl
   import ogru_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = status.is_read ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            // last cell's write lands in the cycle we leave
            if (status.walk_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.walk = 1'b1;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

[hdl/ogru_dp.sv]
// Datapath: odds registers, item registers, line stepper, grid RAM with
// read-modify-write stage, result register. Depends on ogru_pkg, ogru_ram.
module ogru_dp
   import ogru_pkg::*;
#(
   parameter int GRID_SIDE = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   // item
   input  logic                        func,
   input  logic [COORD_W-1:0]          robot_x,
   input  logic [COORD_W-1:0]          robot_y,
   input  logic [COORD_W-1:0]          end_x,
   input  logic [COORD_W-1:0]          end_y,
   input  logic [COORD_W-1:0]          query_x,
   input  logic [COORD_W-1:0]          query_y,
   // config
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_addr,
   input  logic [ODDS_W-1:0]           csr_wdata,
   // result
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [CELL_W-1:0]    cell_value,
   output logic [CNT_W-1:0]            cells_cleared
);

   localparam int DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam int ERR_W = COORD_W + 2;

   function automatic logic on_grid(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y);
      on_grid = (32'(x) < 32'(GRID_SIDE)) && (32'(y) < 32'(GRID_SIDE));
   endfunction

   // off-grid cells map to 0; they are never written
   function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
      logic [31:0] a;
      a = 32'(y) * 32'(GRID_SIDE) + 32'(x);
      cell_addr = on_grid(x, y) ? a[AW-1:0] : '0;
   endfunction

   // ---- config ----
   logic [ODDS_W-1:0] hit_odds_ff, miss_odds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_odds_ff  <= HIT_ODDS_RST;
         miss_odds_ff <= MISS_ODDS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_HIT_ODDS:  hit_odds_ff  <= csr_wdata;
            CSR_MISS_ODDS: miss_odds_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- clearing sweep ----
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // ---- item registers ----
   logic               func_ff;
   logic [COORD_W-1:0] rx_ff, ry_ff, ex_ff, ey_ff, tx_ff, ty_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func;
         rx_ff   <= robot_x;
         ry_ff   <= robot_y;
         ex_ff   <= end_x;
         ey_ff   <= end_y;
         tx_ff   <= (func == FUNC_READ) ? query_x : end_x;
         ty_ff   <= (func == FUNC_READ) ? query_y : end_y;
      end
   end

   // ---- line setup ----
   logic [COORD_W-1:0] adx, ady, s_maj, s_min, s_maj_end, s_min_end, s_dmaj, s_dmin;
   logic               s_steep;

   always_comb begin
      adx       = (ex_ff > rx_ff) ? ex_ff - rx_ff : rx_ff - ex_ff;
      ady       = (ey_ff > ry_ff) ? ey_ff - ry_ff : ry_ff - ey_ff;
      s_steep   = ady > adx;
      s_maj     = s_steep ? ry_ff : rx_ff;
      s_min     = s_steep ? rx_ff : ry_ff;
      s_maj_end = s_steep ? ey_ff : ex_ff;
      s_min_end = s_steep ? ex_ff : ey_ff;
      s_dmaj    = s_steep ? ady : adx;
      s_dmin    = s_steep ? adx : ady;
   end

   // ---- line stepper ----
   logic                     steep_ff, mneg_ff, nneg_ff;
   logic [COORD_W-1:0]       maj_ff, min_ff, dmaj_ff, dmin_ff, cnt_ff;
   logic signed [ERR_W-1:0]  err_ff, err_dec;
   logic [COORD_W-1:0]       walk_x, walk_y;

   assign walk_x  = steep_ff ? min_ff : maj_ff;
   assign walk_y  = steep_ff ? maj_ff : min_ff;
   assign err_dec = err_ff - signed'({2'b00, dmin_ff});

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         steep_ff <= s_steep;
         maj_ff   <= s_maj;
         min_ff   <= s_min;
         dmaj_ff  <= s_dmaj;
         dmin_ff  <= s_dmin;
         mneg_ff  <= !(s_maj_end >= s_maj);
         nneg_ff  <= !(s_min < s_min_end);
         err_ff   <= signed'({2'b00, s_dmaj >> 1});
         cnt_ff   <= '0;
      end else if (cmd.walk) begin
         maj_ff <= mneg_ff ? maj_ff - COORD_W'(1) : maj_ff + COORD_W'(1);
         if (err_dec < 0) begin
            min_ff <= nneg_ff ? min_ff - COORD_W'(1) : min_ff + COORD_W'(1);
            err_ff <= err_dec + signed'({2'b00, dmaj_ff});
         end else begin
            err_ff <= err_dec;
         end
         cnt_ff <= cnt_ff + COORD_W'(1);
      end
   end

   // ---- grid RAM ----
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr, ram_raddr, tgt_addr;
   logic [CELL_W-1:0]        ram_wdata, ram_rdata;
   logic                     tgt_on;

   assign tgt_addr  = cell_addr(tx_ff, ty_ff);
   assign tgt_on    = on_grid(tx_ff, ty_ff);
   assign ram_raddr = cmd.walk ? cell_addr(walk_x, walk_y) : tgt_addr;

   ogru_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // read-modify-write stage for free cells
   logic          p_valid_ff, p_on_ff;
   logic [AW-1:0] p_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= cmd.walk;
      end
   end

   always_ff @(posedge clock) begin
      p_on_ff   <= on_grid(walk_x, walk_y);
      p_addr_ff <= cell_addr(walk_x, walk_y);
   end

   logic signed [CELL_W+1:0]  hit_sum, miss_sum;
   logic signed [CELL_W-1:0]  hit_sat, miss_sat;

   always_comb begin
      hit_sum  = (CELL_W+2)'(signed'(ram_rdata)) + signed'({3'b000, hit_odds_ff});
      miss_sum = (CELL_W+2)'(signed'(ram_rdata)) - signed'({3'b000, miss_odds_ff});
      hit_sat  = (hit_sum >= (CELL_W+2)'(CELL_MAX)) ? CELL_MAX : hit_sum[CELL_W-1:0];
      miss_sat = (miss_sum <= (CELL_W+2)'(CELL_MIN)) ? CELL_MIN : miss_sum[CELL_W-1:0];
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = tgt_addr;
      ram_wdata = hit_sat;
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else if (cmd.look) begin
         ram_we    = tgt_on && (func_ff == FUNC_RAY);
      end else if (p_valid_ff) begin
         ram_we    = p_on_ff;
         ram_waddr = p_addr_ff;
         ram_wdata = miss_sat;
      end
   end

   // ---- item result ----
   logic signed [CELL_W-1:0] value_ff;
   logic [CNT_W-1:0]         cleared_ff;

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         if (!tgt_on) begin
            value_ff <= '0;
         end else if (func_ff == FUNC_READ) begin
            value_ff <= signed'(ram_rdata);
         end else begin
            value_ff <= hit_sat;
         end
      end
      if (cmd.setup) begin
         cleared_ff <= '0;
      end else if (p_valid_ff && p_on_ff) begin
         cleared_ff <= cleared_ff + CNT_W'(1);
      end
   end

   // ---- output register ----
   logic                     rsp_valid_ff;
   logic signed [CELL_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]         rsp_cleared_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff   <= value_ff;
         rsp_cleared_ff <= cleared_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign cell_value    = rsp_value_ff;
   assign cells_cleared = rsp_cleared_ff;

   assign status.clear_last = (clr_addr_ff == LAST_ADDR);
   assign status.is_read    = (func_ff == FUNC_READ);
   assign status.walk_done  = (cnt_ff == dmaj_ff);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

[hdl/occupancy_grid_ray_update.sv]
// Top level of the occupancy grid ray update block.
// Instantiates ogru_ctrl and ogru_dp; depends on ogru_pkg.
//
//  channel  direction  handshake              payload
//  req_     in         req_tvalid/req_tready  tuser: func; tdata: item coordinates
//  rsp_     out        rsp_tvalid/rsp_tready  tdata: cell_value, cells_cleared
//  csr_     in         csr_we (no back-pressure)  csr_addr, csr_wdata
//
// Timing: a read item passes through SETUP, LOOK and DONE after accept; a ray
//   also walks its free cells in WALK, the single grid RAM doing one read-modify-write
//   per free cell (read issued each cycle, write in the cycle after).
// Reset: synchronous, active high. After reset a clearing sweep writes zero to
//   every cell with req_tready low; csr writes are taken throughout.
// Stalls: one item in flight. A finished result sits in the output register
//   while the next item is accepted; the next result waits on rsp_tready.
module occupancy_grid_ray_update
   import ogru_pkg::*;
#(
   parameter int GRID_SIDE = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // item in
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // robot_x, robot_y, end_x, end_y, query_x, query_y
   input  logic                 req_tuser,   // func: 0 ray, 1 read
   // result out
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // cell_value[7:0], cells_cleared[16:8], zero pad
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [ODDS_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   logic signed [CELL_W-1:0] cell_value;
   logic [CNT_W-1:0]         cells_cleared;

   ogru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // item fields unpacked straight from tdata, lowest field first
   ogru_dp #(
      .GRID_SIDE (GRID_SIDE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .func          (req_tuser),
      .robot_x       (req_tdata[7:0]),
      .robot_y       (req_tdata[15:8]),
      .end_x         (req_tdata[23:16]),
      .end_y         (req_tdata[31:24]),
      .query_x       (req_tdata[39:32]),
      .query_y       (req_tdata[47:40]),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .cell_value    (cell_value),
      .cells_cleared (cells_cleared)
   );

   assign rsp_tdata = {7'b0, cells_cleared, cell_value};

endmodule
